// ----- sv/i2a_pkg.sv -----
// Shared constants, codes and the digit character lookup for the integer formatter.
`default_nettype none

package i2a_pkg;

   localparam int VALUE_W           = 64;
   localparam int DEC_DIGITS        = 20;
   localparam int BCD_W             = 4 * DEC_DIGITS;
   localparam int HEX_DIGITS        = 16;
   localparam int HEX_NARROW_DIGITS = 8;
   localparam int FW_W              = 6;
   localparam int CHAR_W            = 7;
   localparam int MAX_WIDTH_DEFAULT = 63;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 8;

   localparam logic [2:0] MODE_UDEC = 3'd0;
   localparam logic [2:0] MODE_SDEC = 3'd1;
   localparam logic [2:0] MODE_LHEX = 3'd2;
   localparam logic [2:0] MODE_UHEX = 3'd3;
   localparam logic [2:0] MODE_PTR  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

   // Map one digit (0 to 15) to its ASCII character, upper or lower case letters.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [CHAR_W-1:0] ch;
      logic [3:0]        off;
      off = nib - 4'd10;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {3'b000, nib};
      end else if (upper) begin
         ch = CH_UPPER_A + {3'b000, off};
      end else begin
         ch = CH_LOWER_A + {3'b000, off};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- sv/i2a_dabble.sv -----
// Iterative binary to BCD converter: one shift-and-adjust step per cycle.
`default_nettype none

module i2a_dabble (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [i2a_pkg::VALUE_W-1:0] value,
   output logic                        done,
   output logic [i2a_pkg::BCD_W-1:0]   bcd
);

   localparam int CNT_W = $clog2(i2a_pkg::VALUE_W);

   logic [i2a_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [i2a_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [i2a_pkg::BCD_W-1:0]   adj;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;

   always_comb begin
      // add 3 to every digit of five or more before the shift
      for (int d = 0; d < i2a_pkg::DEC_DIGITS; d++) begin
         adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                    : bcd_ff[4*d +: 4];
      end
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bin_in = {bin_ff[i2a_pkg::VALUE_W-2:0], 1'b0};
         bcd_in = {adj[i2a_pkg::BCD_W-2:0], bin_ff[i2a_pkg::VALUE_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

// ----- sv/integer_to_ascii_formatter.sv -----
// Top level of the integer formatter: request decode, sequencer and character output.
//
//  channel | direction | tdata                               | tuser      | tlast
//  req_    | in        | value, field_width, zero_fill       | mode, wide | -
//  rsp_    | out       | out_char                            | -          | last
//
// A decimal request runs the converter's 64 shifts, waits for its done flag, counts digits,
// then sends one character per cycle unless rsp_ stalls; hex and pointer go straight out.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// Stalls: a stalled rsp_ side holds the current character; the next request is taken
// only after the last character has been loaded into the output register.
// Reserved modes (5 to 7) are taken and dropped without any item out.
`default_nettype none

module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH = i2a_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [63:0] value, [69:64] field_width, [70] zero_fill, [71] zero
   input  logic [i2a_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] mode, [3] wide
   input  logic [i2a_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [6:0] out_char, [7] zero
   output logic [i2a_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int VW     = i2a_pkg::VALUE_W;
   localparam int FW     = i2a_pkg::FW_W;
   localparam int CW     = i2a_pkg::CHAR_W;
   localparam int ND_W   = $clog2(i2a_pkg::DEC_DIGITS + 1);
   localparam int DIDX_W = $clog2(i2a_pkg::DEC_DIGITS);
   localparam logic [FW-1:0]   MAX_W    = FW'(MAX_WIDTH);
   localparam logic [FW-1:0]   HEX_WIDE = FW'(i2a_pkg::HEX_DIGITS);
   localparam logic [FW-1:0]   HEX_NARR = FW'(i2a_pkg::HEX_NARROW_DIGITS);
   localparam logic [FW-1:0]   DEC_CNT  = FW'(i2a_pkg::DEC_DIGITS);
   localparam logic [ND_W-1:0] HEX_ND   = ND_W'(i2a_pkg::HEX_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_COUNT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                  neg_ff, neg_in;
   logic                  upper_ff, upper_in;
   logic [CW-1:0]         pad_ch_ff, pad_ch_in;
   logic [FW-1:0]         width_ff, width_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [FW-1:0]         pos_ff, pos_in;
   logic [i2a_pkg::BCD_W-1:0] digits_ff, digits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   // request fields
   logic [2:0]    req_mode;
   logic          req_wide;
   logic [VW-1:0] req_value;
   logic [FW-1:0] req_fw;
   logic          req_zpad;

   logic          req_fire;
   logic          emit_fire;
   logic [FW-1:0] fw_sat;
   logic [VW-1:0] dec_val;
   logic          dec_neg;
   logic [VW-1:0] dec_mag;
   logic          hex_wide;
   logic [VW-1:0] hex_val;
   logic [FW-1:0] hex_width;
   logic          dab_start;
   logic          dab_done;
   logic [i2a_pkg::BCD_W-1:0] dab_bcd;
   logic [ND_W-1:0] cnt_nd;
   logic [FW-1:0]   field_len;
   logic [DIDX_W-1:0] dig_idx;
   logic [3:0]      dig_nib;

   assign req_mode  = req_tuser[2:0];
   assign req_wide  = req_tuser[3];
   assign req_value = req_tdata[VW-1:0];
   assign req_fw    = req_tdata[VW+FW-1:VW];
   assign req_zpad  = req_tdata[VW+FW];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign emit_fire  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // saturate the field width, then work out both decimal and hex operands
   assign fw_sat = (req_fw > MAX_W) ? MAX_W : req_fw;

   always_comb begin
      if (req_wide) begin
         dec_val = req_value;
      end else if (req_mode == i2a_pkg::MODE_SDEC) begin
         dec_val = {{(VW/2){req_value[VW/2-1]}}, req_value[VW/2-1:0]};
      end else begin
         dec_val = {{(VW/2){1'b0}}, req_value[VW/2-1:0]};
      end
      dec_neg   = (req_mode == i2a_pkg::MODE_SDEC) && dec_val[VW-1];
      dec_mag   = dec_neg ? (VW'(0) - dec_val) : dec_val;
      hex_wide  = req_wide || (req_mode == i2a_pkg::MODE_PTR);
      hex_val   = hex_wide ? req_value : {{(VW/2){1'b0}}, req_value[VW/2-1:0]};
      hex_width = (fw_sat != '0) ? fw_sat : (hex_wide ? HEX_WIDE : HEX_NARR);
   end

   assign dab_start = req_fire && (req_mode inside {i2a_pkg::MODE_UDEC, i2a_pkg::MODE_SDEC});

   i2a_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .value (dec_mag),
      .done  (dab_done),
      .bcd   (dab_bcd)
   );

   // number of significant decimal digits, at least one
   always_comb begin
      cnt_nd = ND_W'(1);
      for (int d = 1; d < i2a_pkg::DEC_DIGITS; d++) begin
         if (dab_bcd[4*d +: 4] != 4'd0) begin
            cnt_nd = ND_W'(d + 1);
         end
      end
      field_len = (width_ff > FW'(cnt_nd)) ? width_ff : FW'(cnt_nd);
   end

   // current digit: only meaningful while the position lies below the digit count
   assign dig_idx = (pos_ff < DEC_CNT) ? pos_ff[DIDX_W-1:0] : '0;
   assign dig_nib = digits_ff[4*dig_idx +: 4];

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      pad_ch_in    = pad_ch_ff;
      width_in     = width_ff;
      nd_in        = nd_ff;
      pos_in       = pos_ff;
      digits_in    = digits_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode inside {i2a_pkg::MODE_UDEC, i2a_pkg::MODE_SDEC}) begin
                  neg_in    = dec_neg;
                  upper_in  = 1'b0;
                  pad_ch_in = req_zpad ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
                  width_in  = fw_sat;
                  state_in  = ST_CONV;
               end else if (req_mode inside {[i2a_pkg::MODE_LHEX : i2a_pkg::MODE_PTR]}) begin
                  // hex: digits are the nibbles themselves, higher places pad with zero
                  neg_in    = 1'b0;
                  upper_in  = (req_mode == i2a_pkg::MODE_UHEX);
                  pad_ch_in = i2a_pkg::CH_ZERO;
                  width_in  = hex_width;
                  nd_in     = HEX_ND;
                  pos_in    = hex_width - 1'b1;
                  digits_in = {{(i2a_pkg::BCD_W-VW){1'b0}}, hex_val};
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_CONV: begin
            if (dab_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            digits_in = dab_bcd;
            nd_in     = cnt_nd;
            pos_in    = field_len - 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  // sign goes out ahead of the padding
                  rsp_char_in = i2a_pkg::CH_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = (pos_ff >= FW'(nd_ff)) ? pad_ch_ff
                                                       : i2a_pkg::digit_char(dig_nib, upper_ff);
                  rsp_last_in = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      pad_ch_ff   <= pad_ch_in;
      width_ff    <= width_in;
      nd_ff       <= nd_in;
      pos_ff      <= pos_in;
      digits_ff   <= digits_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(i2a_pkg::RSP_DATA_W-CW){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the converter only finishes while the sequencer waits for it
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      dab_done |-> (state_ff == ST_CONV))
      else $error("converter finished outside the conversion state");

   // a valid request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode <= i2a_pkg::MODE_PTR)) |=> !req_tready)
      else $error("block ready again straight after a valid request");

   // a minus sign is never the closing character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[CW-1:0] == i2a_pkg::CH_MINUS)) |-> !rsp_tlast)
      else $error("minus sign flagged as last character");
`endif

endmodule

`default_nettype wire
